@@ hdl/i2cms_pkg.sv @@
// Shared types and constants for the I2C master message sequencer.
// Holds the command, phase and register codes and the controller/datapath structs.
// No dependencies.
package i2cms_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_LOAD_DESC = 2'd0;
  localparam logic [1:0] CMD_LOAD_BYTE = 2'd1;
  localparam logic [1:0] CMD_START     = 2'd2;
  localparam logic [1:0] CMD_EVENT     = 2'd3;

  // Transfer phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;
  localparam logic [1:0] PH_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_CLK_DIV = 1'b0;
  localparam logic CFG_CLK_SEL = 1'b1;

  // Status register words for the controller.
  localparam logic [7:0] STAT_START_RD = 8'hb0;
  localparam logic [7:0] STAT_START_WR = 8'hf0;
  localparam logic [7:0] STAT_STOP_RD  = 8'h90;
  localparam logic [7:0] STAT_STOP_WR  = 8'hd0;

  // Control register words and bits.
  localparam logic [7:0] CON_RESET = 8'haf;
  localparam logic [7:0] CON_PEND  = 8'h10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc;         // word accepted this cycle
    logic exec;        // main step of the item
    logic ld_start;    // take message count, rewind to message 0
    logic adv_msg;     // move on to the next message
    logic ptr_inc;     // advance the byte pointer
    logic con_upd;     // load a new control word
    logic con_ack;     // ack bit of that word
    logic emit_con;    // control register write in the result
    logic emit_wbyte;  // data register write of the next write byte
    logic emit_addr;   // address byte and start status word
    logic emit_stop;   // stop status word and done flag
    logic err;         // no-acknowledge code with the stop
    logic emit_read;   // deliver the received byte
    logic fire;        // result complete, strobe it
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;         // latched command of the item
    logic       nack;        // latched acknowledge bit
    logic       rd;          // current message is a read
    logic       ptr_lt_len;  // pointer below length
    logic       ptr1_lt_len; // pointer plus one below length
    logic       ptr1_ne_len; // pointer plus one differs from length
    logic       ptr2_ne_len; // pointer plus two differs from length
    logic       more;        // another message follows this one
  } dp_stat_t;

  // Control word: ack, clock source, interrupt enable, pending clear, divider.
  function automatic logic [7:0] con_word(input logic ack, input logic sel,
                                          input logic [3:0] div);
    con_word = {ack, sel, 1'b1, 1'b0, div};
  endfunction

endpackage

@@ hdl/i2c_master_message_sequencer_core.sv @@
// I2C master message sequencer: one result word per accepted command word.
// The result strobe is registered after the main step; for a start and for an event
// that moves to the next message it follows the address byte step instead. A new
// word is taken only once the core is idle again after these steps. Reset is
// synchronous and active low; the stores need no clearing pass, so a word is taken
// right after reset.
module i2c_master_message_sequencer_core #(
  parameter int MAX_MSGS = 8,
  parameter int MAX_LEN  = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [2:0] in_msg_index,
  input  logic [6:0] in_dev_addr,
  input  logic       in_is_read,
  input  logic [8:0] in_msg_length,
  input  logic [7:0] in_byte_pos,
  input  logic [7:0] in_data_byte,
  input  logic [3:0] in_msg_count,
  input  logic       in_nack,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata,
  output logic       out_valid,
  output logic       out_data_reg_write,
  output logic [7:0] out_data_reg_value,
  output logic       out_stat_reg_write,
  output logic [7:0] out_stat_reg_value,
  output logic       out_con_reg_write,
  output logic [7:0] out_con_reg_value,
  output logic       out_read_valid,
  output logic [2:0] out_read_msg,
  output logic [7:0] out_read_pos,
  output logic [7:0] out_read_byte,
  output logic       out_done_res,
  output logic       out_error_code
);
  import i2cms_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Controller.
  i2cms_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath.
  i2cms_dp #(
    .MAX_MSGS (MAX_MSGS),
    .MAX_LEN  (MAX_LEN)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_command         (in_command),
    .in_msg_index       (in_msg_index),
    .in_dev_addr        (in_dev_addr),
    .in_is_read         (in_is_read),
    .in_msg_length      (in_msg_length),
    .in_byte_pos        (in_byte_pos),
    .in_data_byte       (in_data_byte),
    .in_msg_count       (in_msg_count),
    .in_nack            (in_nack),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_data_reg_write (out_data_reg_write),
    .out_data_reg_value (out_data_reg_value),
    .out_stat_reg_write (out_stat_reg_write),
    .out_stat_reg_value (out_stat_reg_value),
    .out_con_reg_write  (out_con_reg_write),
    .out_con_reg_value  (out_con_reg_value),
    .out_read_valid     (out_read_valid),
    .out_read_msg       (out_read_msg),
    .out_read_pos       (out_read_pos),
    .out_read_byte      (out_read_byte),
    .out_done_res       (out_done_res),
    .out_error_code     (out_error_code)
  );

endmodule

@@ hdl/i2cms_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/i2cms_ctrl.sv @@
// Controller state machine of the I2C master message sequencer.
// Depends on i2cms_pkg; drives i2cms_dp through command and status structs.
module i2cms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  i2cms_pkg::dp_stat_t stat,
  output logic                busy,
  output i2cms_pkg::ctrl_cmd_t cmd
);
  import i2cms_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_BEGIN = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       wstep, tail, tail_lt, tail_ack, nos, fin, fin_err;

  assign busy = (st_r != S_IDLE);

  // Sequencing and transfer decisions.
  always_comb begin
    cmd      = '0;
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    wstep    = 1'b0;
    tail     = 1'b0;
    tail_lt  = 1'b0;
    tail_ack = 1'b0;
    nos      = 1'b0;
    fin      = 1'b0;
    fin_err  = 1'b0;
    cmd.acc  = start && !busy;
    case (st_r)
      S_IDLE: begin
        if (cmd.acc) begin
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        st_nxt   = S_IDLE;
        case (stat.cmd)
          CMD_START: begin
            cmd.ld_start = 1'b1;
            st_nxt       = S_BEGIN;
          end
          CMD_EVENT: begin
            cmd.emit_con = 1'b1;
            case (ph_r)
              PH_START: begin
                if (stat.nack) begin
                  fin     = 1'b1;
                  fin_err = 1'b1;
                end else if (!stat.more && !stat.ptr_lt_len) begin
                  fin = 1'b1;
                end else if (stat.rd) begin
                  ph_nxt   = PH_READ;
                  tail     = 1'b1;
                  tail_lt  = stat.ptr_lt_len;
                  tail_ack = stat.ptr1_ne_len;
                end else begin
                  ph_nxt = PH_WRITE;
                  wstep  = 1'b1;
                end
              end
              PH_WRITE: begin
                wstep = 1'b1;
              end
              PH_READ: begin
                cmd.emit_read = 1'b1;
                cmd.ptr_inc   = 1'b1;
                tail          = 1'b1;
                tail_lt       = stat.ptr1_lt_len;
                tail_ack      = stat.ptr2_ne_len;
              end
              default: begin
              end
            endcase
            // Write step: check the acknowledge, then send a byte or move on.
            if (wstep) begin
              if (stat.nack) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else if (stat.ptr_lt_len) begin
                cmd.emit_wbyte = 1'b1;
                cmd.ptr_inc    = 1'b1;
                cmd.con_upd    = 1'b1;
                cmd.con_ack    = 1'b1;
              end else begin
                nos = 1'b1;
              end
            end
            // Read tail: withhold ACK before the last byte, or move on.
            if (tail) begin
              if (tail_lt) begin
                cmd.con_upd = 1'b1;
                cmd.con_ack = tail_ack;
              end else begin
                nos = 1'b1;
              end
            end
            // Repeated start for the next message, or stop.
            if (nos) begin
              if (stat.more) begin
                cmd.adv_msg = 1'b1;
                st_nxt      = S_BEGIN;
              end else begin
                fin = 1'b1;
              end
            end
            if (fin) begin
              cmd.emit_stop = 1'b1;
              cmd.err       = fin_err;
              cmd.con_upd   = 1'b1;
              cmd.con_ack   = 1'b1;
              ph_nxt        = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
        cmd.fire = (st_nxt != S_BEGIN);
      end
      S_BEGIN: begin
        cmd.emit_addr = 1'b1;
        cmd.fire      = 1'b1;
        ph_nxt        = PH_START;
        st_nxt        = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ph_r <= PH_IDLE;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
    end
  end

endmodule

@@ hdl/i2cms_dp.sv @@
// Datapath of the I2C master message sequencer: descriptor table, write byte
// store, pointers, control word and result registers.
// Depends on i2cms_pkg and i2cms_ram; commanded by i2cms_ctrl.
module i2cms_dp #(
  parameter int MAX_MSGS = 8,
  parameter int MAX_LEN  = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cms_pkg::ctrl_cmd_t cmd,
  output i2cms_pkg::dp_stat_t  stat,
  input  logic [1:0]           in_command,
  input  logic [2:0]           in_msg_index,
  input  logic [6:0]           in_dev_addr,
  input  logic                 in_is_read,
  input  logic [8:0]           in_msg_length,
  input  logic [7:0]           in_byte_pos,
  input  logic [7:0]           in_data_byte,
  input  logic [3:0]           in_msg_count,
  input  logic                 in_nack,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [3:0]           cfg_wdata,
  output logic                 out_valid,
  output logic                 out_data_reg_write,
  output logic [7:0]           out_data_reg_value,
  output logic                 out_stat_reg_write,
  output logic [7:0]           out_stat_reg_value,
  output logic                 out_con_reg_write,
  output logic [7:0]           out_con_reg_value,
  output logic                 out_read_valid,
  output logic [2:0]           out_read_msg,
  output logic [7:0]           out_read_pos,
  output logic [7:0]           out_read_byte,
  output logic                 out_done_res,
  output logic                 out_error_code
);
  import i2cms_pkg::*;

  localparam int MSG_W  = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
  localparam int TOT_W  = $clog2(MAX_MSGS + 1);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int DEPTH  = MAX_MSGS * MAX_LEN;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Descriptor table.
  logic [6:0]       desc_addr [MAX_MSGS];
  logic             desc_rd   [MAX_MSGS];
  logic [LEN_W-1:0] desc_len  [MAX_MSGS];

  // Sequencing state.
  logic [MSG_W-1:0] cur_r;
  logic [LEN_W-1:0] ptr_r;
  logic [TOT_W-1:0] tot_r;
  logic [7:0]       con_r;
  logic [3:0]       div_r;
  logic             sel_r;

  // Item words held for the main step.
  logic [1:0] cmd_q;
  logic       nack_q;
  logic [7:0] byte_q;
  logic [3:0] count_q;

  logic             idx_ok, pos_ok;
  logic [LEN_W-1:0] len_sat;
  logic [MSG_W-1:0] idx_w;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_rdata;
  logic [6:0]       cur_addr;
  logic             cur_rd;
  logic [LEN_W-1:0] cur_len;
  logic [LEN_W:0]   ptr1, ptr2, len_x;
  logic [TOT_W-1:0] cnt_sat;
  logic [7:0]       con_val;
  logic             valid_r;

  // Load decode and range checks.
  assign idx_ok  = (32'(in_msg_index) < 32'(MAX_MSGS));
  assign pos_ok  = (32'(in_byte_pos) < 32'(MAX_LEN));
  assign len_sat = (32'(in_msg_length) > 32'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                      : LEN_W'(in_msg_length);
  assign idx_w   = MSG_W'(in_msg_index);

  // Write byte store, addressed by message slot and byte position.
  assign ram_we    = cmd.acc && (in_command == CMD_LOAD_BYTE) && idx_ok && pos_ok;
  assign ram_waddr = ADDR_W'(32'(in_msg_index) * MAX_LEN + 32'(in_byte_pos));
  assign ram_raddr = ADDR_W'(32'(cur_r) * MAX_LEN + 32'(ptr_r));

  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Descriptor writes.
  always_ff @(posedge clk) begin
    if (cmd.acc && (in_command == CMD_LOAD_DESC) && idx_ok) begin
      desc_addr[idx_w] <= in_dev_addr;
      desc_rd[idx_w]   <= in_is_read;
      desc_len[idx_w]  <= len_sat;
    end
  end

  // Current descriptor and pointer comparisons.
  assign cur_addr = desc_addr[cur_r];
  assign cur_rd   = desc_rd[cur_r];
  assign cur_len  = desc_len[cur_r];
  assign ptr1     = (LEN_W+1)'(ptr_r) + (LEN_W+1)'(1);
  assign ptr2     = (LEN_W+1)'(ptr_r) + (LEN_W+1)'(2);
  assign len_x    = (LEN_W+1)'(cur_len);

  assign stat.cmd         = cmd_q;
  assign stat.nack        = nack_q;
  assign stat.rd          = cur_rd;
  assign stat.ptr_lt_len  = (ptr_r < cur_len);
  assign stat.ptr1_lt_len = (ptr1 < len_x);
  assign stat.ptr1_ne_len = (ptr1 != len_x);
  assign stat.ptr2_ne_len = (ptr2 != len_x);
  assign stat.more        = ((32'(cur_r) + 32'd1) < 32'(tot_r));

  // Message count clamped to one up to the table depth.
  always_comb begin
    if (count_q == 4'd0) begin
      cnt_sat = TOT_W'(1);
    end else if (32'(count_q) > 32'(MAX_MSGS)) begin
      cnt_sat = TOT_W'(MAX_MSGS);
    end else begin
      cnt_sat = TOT_W'(count_q);
    end
  end

  // Control word after this step, pending bit cleared.
  assign con_val = cmd.con_upd ? con_word(cmd.con_ack, sel_r, div_r) : con_r;

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      cmd_q   <= in_command;
      nack_q  <= in_nack;
      byte_q  <= in_data_byte;
      count_q <= in_msg_count;
    end
  end

  // Sequencing state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      ptr_r <= '0;
      tot_r <= TOT_W'(1);
      con_r <= CON_RESET;
      div_r <= 4'hf;
      sel_r <= 1'b0;
    end else begin
      if (cmd.ld_start) begin
        cur_r <= '0;
        ptr_r <= '0;
        tot_r <= cnt_sat;
      end else if (cmd.adv_msg) begin
        cur_r <= cur_r + MSG_W'(1);
        ptr_r <= '0;
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_r + LEN_W'(1);
      end
      if (cmd.con_upd) begin
        con_r <= con_val;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CLK_DIV: div_r <= cfg_wdata;
          CFG_CLK_SEL: sel_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result registers: the main step clears and fills them, the begin step
  // adds the address byte and start word.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data_reg_write <= cmd.emit_wbyte;
      out_data_reg_value <= cmd.emit_wbyte ? ram_rdata : 8'd0;
      out_stat_reg_write <= cmd.emit_stop;
      out_stat_reg_value <= cmd.emit_stop ? (cur_rd ? STAT_STOP_RD : STAT_STOP_WR) : 8'd0;
      out_con_reg_write  <= cmd.emit_con;
      out_con_reg_value  <= cmd.emit_con ? (con_val & ~CON_PEND) : 8'd0;
      out_read_valid     <= cmd.emit_read;
      out_read_msg       <= cmd.emit_read ? 3'(cur_r) : 3'd0;
      out_read_pos       <= cmd.emit_read ? 8'(ptr_r) : 8'd0;
      out_read_byte      <= cmd.emit_read ? byte_q : 8'd0;
      out_done_res       <= cmd.emit_stop;
      out_error_code     <= cmd.emit_stop && cmd.err;
    end else if (cmd.emit_addr) begin
      out_data_reg_write <= 1'b1;
      out_data_reg_value <= {cur_addr, cur_rd};
      out_stat_reg_write <= 1'b1;
      out_stat_reg_value <= cur_rd ? STAT_START_RD : STAT_START_WR;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.fire;
    end
  end

  assign out_valid = valid_r;

endmodule

@@ tb/i2cms_transfer_checker.sv @@
`timescale 1ns / 100ps
// Checker for the I2C master message sequencer: keeps its own copy of the sequencer state,
// works out the register writes for every accepted command word and compares each result.
// Depends on i2cms_pkg for the command, phase, register index and status word codes.
module i2cms_transfer_checker #(
  parameter int SLOTS    = 8,
  parameter int SLOT_LEN = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_command,
  input  logic [2:0] in_msg_index,
  input  logic [6:0] in_dev_addr,
  input  logic       in_is_read,
  input  logic [8:0] in_msg_length,
  input  logic [7:0] in_byte_pos,
  input  logic [7:0] in_data_byte,
  input  logic [3:0] in_msg_count,
  input  logic       in_nack,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata,
  input  logic       out_valid,
  input  logic       out_data_reg_write,
  input  logic [7:0] out_data_reg_value,
  input  logic       out_stat_reg_write,
  input  logic [7:0] out_stat_reg_value,
  input  logic       out_con_reg_write,
  input  logic [7:0] out_con_reg_value,
  input  logic       out_read_valid,
  input  logic [2:0] out_read_msg,
  input  logic [7:0] out_read_pos,
  input  logic [7:0] out_read_byte,
  input  logic       out_done_res,
  input  logic       out_error_code,
  output int         fail_count,
  output int         pending,
  output int         results_checked,
  output int         stops_ok,
  output int         stops_nack,
  output int         bytes_read
);
  import i2cms_pkg::*;

  localparam logic [7:0] ACK_BIT   = 8'h80;
  localparam logic [7:0] IRQ_EN    = 8'h20;
  localparam logic [3:0] DIV_RESET = 4'hf;

  // One result word: the register writes and the delivered byte of one step.
  typedef struct packed {
    logic       data_wr;
    logic [7:0] data_val;
    logic       stat_wr;
    logic [7:0] stat_val;
    logic       con_wr;
    logic [7:0] con_val;
    logic       rd_valid;
    logic [2:0] rd_msg;
    logic [7:0] rd_pos;
    logic [7:0] rd_byte;
    logic       done;
    logic       err;
  } reg_writes_t;

  // Mirror of the sequencer state and its clock configuration.
  logic [6:0]  slot_addr [SLOTS];
  logic        slot_rd   [SLOTS];
  logic [8:0]  slot_len  [SLOTS];
  logic [7:0]  tx_bytes  [SLOTS*SLOT_LEN];
  logic [1:0]  phase_now;
  logic [2:0]  msg_now;
  logic [8:0]  byte_ptr;
  logic [3:0]  msg_total;
  logic [7:0]  last_con;
  logic [3:0]  clk_div;
  logic        clk_sel;
  reg_writes_t step_out;
  reg_writes_t expected_writes [$];

  function automatic logic [7:0] ctl_word(input logic ack);
    return (ack ? ACK_BIT : 8'h00) | {1'b0, clk_sel, 6'b0} | IRQ_EN | {4'h0, clk_div};
  endfunction

  function automatic void note_field(input string fname, input logic [8:0] want,
                                     input logic [8:0] got);
    if (got !== want) begin
      if (fail_count < 10)
        $display("Result %0d, %s: expected 0x%0h, got 0x%0h",
                 results_checked, fname, want, got);
      fail_count++;
    end
  endfunction

  task automatic clear_state();
    for (int i = 0; i < SLOTS; i++) begin
      slot_addr[i] = '0;
      slot_rd[i]   = 1'b0;
      slot_len[i]  = '0;
    end
    for (int i = 0; i < SLOTS * SLOT_LEN; i++)
      tx_bytes[i] = '0;
    phase_now = PH_IDLE;
    msg_now   = '0;
    byte_ptr  = '0;
    msg_total = 4'd1;
    last_con  = CON_RESET;
    clk_div   = DIV_RESET;
    clk_sel   = 1'b0;
  endtask

  // Address byte and start word of the current message.
  task automatic open_message();
    phase_now         = PH_START;
    step_out.data_wr  = 1'b1;
    step_out.data_val = {slot_addr[msg_now], slot_rd[msg_now]};
    step_out.stat_wr  = 1'b1;
    step_out.stat_val = slot_rd[msg_now] ? STAT_START_RD : STAT_START_WR;
  endtask

  // Stop word and completion code; the control word goes back to acknowledging.
  task automatic close_transfer(input logic nak);
    step_out.stat_wr  = 1'b1;
    step_out.stat_val = slot_rd[msg_now] ? STAT_STOP_RD : STAT_STOP_WR;
    last_con          = ctl_word(1'b1);
    step_out.done     = 1'b1;
    step_out.err      = nak;
    phase_now         = PH_IDLE;
  endtask

  task automatic next_or_close();
    if (int'(msg_now) + 1 < int'(msg_total)) begin
      msg_now++;
      byte_ptr = '0;
      open_message();
    end else begin
      close_transfer(1'b0);
    end
  endtask

  // ACK is withheld when the next byte to arrive is the last of the message.
  task automatic read_after();
    if (byte_ptr < slot_len[msg_now])
      last_con = ctl_word(int'(byte_ptr) + 1 != int'(slot_len[msg_now]));
    else
      next_or_close();
  endtask

  task automatic write_next(input logic nak);
    if (nak) begin
      close_transfer(1'b1);
    end else if (byte_ptr < slot_len[msg_now]) begin
      step_out.data_wr  = 1'b1;
      step_out.data_val = tx_bytes[int'(msg_now) * SLOT_LEN + int'(byte_ptr)];
      byte_ptr++;
      last_con = ctl_word(1'b1);
    end else begin
      next_or_close();
    end
  endtask

  // Works out the result word of the command word on the input ports.
  task automatic predict_register_writes();
    int count;
    int len;
    step_out = '0;
    case (in_command)
      CMD_LOAD_DESC: begin
        len = (int'(in_msg_length) > SLOT_LEN) ? SLOT_LEN : int'(in_msg_length);
        slot_addr[in_msg_index] = in_dev_addr;
        slot_rd[in_msg_index]   = in_is_read;
        slot_len[in_msg_index]  = 9'(len);
      end
      CMD_LOAD_BYTE: begin
        tx_bytes[int'(in_msg_index) * SLOT_LEN + int'(in_byte_pos)] = in_data_byte;
      end
      CMD_START: begin
        count = int'(in_msg_count);
        if (count == 0)
          count = 1;
        if (count > SLOTS)
          count = SLOTS;
        msg_total = 4'(count);
        msg_now   = '0;
        byte_ptr  = '0;
        open_message();
      end
      default: begin
        case (phase_now)
          PH_START: begin
            if (in_nack) begin
              close_transfer(1'b1);
            end else if (int'(msg_now) + 1 >= int'(msg_total) &&
                         byte_ptr >= slot_len[msg_now]) begin
              close_transfer(1'b0);
            end else if (slot_rd[msg_now]) begin
              phase_now = PH_READ;
              read_after();
            end else begin
              phase_now = PH_WRITE;
              write_next(in_nack);
            end
          end
          PH_WRITE: write_next(in_nack);
          PH_READ: begin
            step_out.rd_valid = 1'b1;
            step_out.rd_msg   = msg_now;
            step_out.rd_pos   = byte_ptr[7:0];
            step_out.rd_byte  = in_data_byte;
            byte_ptr++;
            read_after();
          end
          default: ;
        endcase
        step_out.con_wr  = 1'b1;
        step_out.con_val = last_con & ~CON_PEND;
      end
    endcase
  endtask

  // Results are checked before the word accepted at the same edge is predicted.
  always @(posedge clk) begin : watch
    reg_writes_t want;
    reg_writes_t got;
    if (!rst_n) begin
      clear_state();
      expected_writes.delete();
      fail_count      = 0;
      results_checked = 0;
      stops_ok        = 0;
      stops_nack      = 0;
      bytes_read      = 0;
    end else begin
      if (out_valid) begin
        got = {out_data_reg_write, out_data_reg_value, out_stat_reg_write,
               out_stat_reg_value, out_con_reg_write, out_con_reg_value,
               out_read_valid, out_read_msg, out_read_pos, out_read_byte,
               out_done_res, out_error_code};
        if (expected_writes.size() == 0) begin
          if (fail_count < 10)
            $display("Result %0d arrived with nothing expected: 0x%0h",
                     results_checked, got);
          fail_count++;
        end else begin
          want = expected_writes.pop_front();
          note_field("data_reg_write", 9'(want.data_wr), 9'(got.data_wr));
          note_field("data_reg_value", 9'(want.data_val), 9'(got.data_val));
          note_field("stat_reg_write", 9'(want.stat_wr), 9'(got.stat_wr));
          note_field("stat_reg_value", 9'(want.stat_val), 9'(got.stat_val));
          note_field("con_reg_write", 9'(want.con_wr), 9'(got.con_wr));
          note_field("con_reg_value", 9'(want.con_val), 9'(got.con_val));
          note_field("read_valid", 9'(want.rd_valid), 9'(got.rd_valid));
          note_field("read_msg", 9'(want.rd_msg), 9'(got.rd_msg));
          note_field("read_pos", 9'(want.rd_pos), 9'(got.rd_pos));
          note_field("read_byte", 9'(want.rd_byte), 9'(got.rd_byte));
          note_field("done_res", 9'(want.done), 9'(got.done));
          note_field("error_code", 9'(want.err), 9'(got.err));
          if (want.done && want.err)
            stops_nack++;
          else if (want.done)
            stops_ok++;
          if (want.rd_valid)
            bytes_read++;
        end
        results_checked++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CLK_DIV)
          clk_div = cfg_wdata;
        else
          clk_sel = cfg_wdata[0];
      end
      if (start && !busy) begin
        predict_register_writes();
        expected_writes.push_back(step_out);
      end
    end
    pending = expected_writes.size();
  end

endmodule

@@ tb/i2c_master_message_sequencer_core_test.sv @@
`timescale 1ns / 100ps
// Top of the I2C master message sequencer testbench: clock, reset, command words and verdict.
// Depends on i2cms_pkg, the sequencer core and i2cms_transfer_checker.
module i2c_master_message_sequencer_core_test;
  import i2cms_pkg::*;

  localparam int SLOTS       = 8;
  localparam int SLOT_LEN    = 256;
  localparam int PHASES      = 6;
  localparam int WORD_TARGET = 1850;
  localparam int STALL_LIMIT = 2000;

  // One command word with every field of the input channel.
  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] slot;
    logic [6:0] addr;
    logic       rd;
    logic [8:0] len;
    logic [7:0] pos;
    logic [7:0] data;
    logic [3:0] cnt;
    logic       nack;
  } seq_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_command = '0;
  logic [2:0] in_msg_index = '0;
  logic [6:0] in_dev_addr = '0;
  logic       in_is_read = 1'b0;
  logic [8:0] in_msg_length = '0;
  logic [7:0] in_byte_pos = '0;
  logic [7:0] in_data_byte = '0;
  logic [3:0] in_msg_count = '0;
  logic       in_nack = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_CLK_DIV;
  logic [3:0] cfg_wdata = '0;
  logic       out_valid;
  logic       out_data_reg_write;
  logic [7:0] out_data_reg_value;
  logic       out_stat_reg_write;
  logic [7:0] out_stat_reg_value;
  logic       out_con_reg_write;
  logic [7:0] out_con_reg_value;
  logic       out_read_valid;
  logic [2:0] out_read_msg;
  logic [7:0] out_read_pos;
  logic [7:0] out_read_byte;
  logic       out_done_res;
  logic       out_error_code;
  int         fail_count;
  int         pending;
  int         results_checked;
  int         stops_ok;
  int         stops_nack;
  int         bytes_read;

  // Stimulus bookkeeping: which descriptors and write bytes hold loaded values.
  int         idle_pct = 0;
  int         words_sent = 0;
  bit         desc_known [SLOTS];
  int         known_len [SLOTS];
  bit         byte_known [SLOTS*SLOT_LEN];
  int         written_prefix [SLOTS];

  i2c_master_message_sequencer_core uut (.*);

  i2cms_transfer_checker check_u (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Every field starts random so that unused fields still toggle.
  function automatic seq_word_t blank_word(input logic [1:0] cmd);
    seq_word_t w;
    w.cmd  = cmd;
    w.slot = 3'($urandom_range(0, 7));
    w.addr = 7'($urandom_range(0, 127));
    w.rd   = 1'($urandom_range(0, 1));
    w.len  = 9'($urandom_range(0, 511));
    w.pos  = 8'($urandom_range(0, 255));
    w.data = 8'($urandom_range(0, 255));
    w.cnt  = 4'($urandom_range(0, 15));
    w.nack = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Drives one word, with a random sender gap first, and waits until it is taken.
  task automatic put_word(input seq_word_t w);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_command    <= w.cmd;
    in_msg_index  <= w.slot;
    in_dev_addr   <= w.addr;
    in_is_read    <= w.rd;
    in_msg_length <= w.len;
    in_byte_pos   <= w.pos;
    in_data_byte  <= w.data;
    in_msg_count  <= w.cnt;
    in_nack       <= w.nack;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic load_byte(input int slot, input int pos, input logic [7:0] data);
    seq_word_t w;
    w      = blank_word(CMD_LOAD_BYTE);
    w.slot = 3'(slot);
    w.pos  = 8'(pos);
    w.data = data;
    put_word(w);
    byte_known[slot * SLOT_LEN + pos] = 1'b1;
    while (written_prefix[slot] < SLOT_LEN &&
           byte_known[slot * SLOT_LEN + written_prefix[slot]])
      written_prefix[slot]++;
  endtask

  task automatic load_desc(input int slot, input logic [6:0] addr, input logic rd,
                           input int len);
    seq_word_t w;
    w      = blank_word(CMD_LOAD_DESC);
    w.slot = 3'(slot);
    w.addr = addr;
    w.rd   = rd;
    w.len  = 9'(len);
    put_word(w);
    desc_known[slot] = 1'b1;
    known_len[slot]  = (len > SLOT_LEN) ? SLOT_LEN : len;
  endtask

  task automatic begin_transfer(input logic [3:0] cnt);
    seq_word_t w;
    w     = blank_word(CMD_START);
    w.cnt = cnt;
    put_word(w);
  endtask

  task automatic ctl_event(input logic nack, input logic [7:0] data);
    seq_word_t w;
    w      = blank_word(CMD_EVENT);
    w.nack = nack;
    w.data = data;
    put_word(w);
  endtask

  // Write bytes of a slot are loaded up to the given length before any use.
  task automatic ensure_bytes(input int slot, input int upto);
    while (written_prefix[slot] < upto)
      load_byte(slot, written_prefix[slot], 8'($urandom_range(0, 255)));
  endtask

  // New descriptor for a slot, mostly short messages.
  task automatic fresh_message(input int slot);
    int   len;
    int   roll;
    logic rd;
    rd   = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 60)
      len = $urandom_range(0, 4);
    else if (roll < 92)
      len = $urandom_range(5, 12);
    else
      len = $urandom_range(13, 40);
    if (!rd) begin
      ensure_bytes(slot, len);
      if (len > 0 && $urandom_range(0, 1))
        load_byte(slot, $urandom_range(0, len - 1), 8'($urandom_range(0, 255)));
    end
    load_desc(slot, 7'($urandom_range(0, 127)), rd, len);
  endtask

  // Descriptor reload in the middle of a transfer; a write never outruns its bytes.
  task automatic stray_desc();
    int   slot;
    logic rd;
    slot = $urandom_range(0, SLOTS - 1);
    rd   = 1'($urandom_range(0, 1));
    if (rd)
      load_desc(slot, 7'($urandom_range(0, 127)), rd, $urandom_range(0, 511));
    else
      load_desc(slot, 7'($urandom_range(0, 127)), rd,
                $urandom_range(0, written_prefix[slot]));
  endtask

  // One combined transfer: descriptors, start, then controller events with rare
  // no-acknowledges, stray loads and now and then a cut-short event stream.
  // A big kind of 1 makes a saturated-length read, 2 a full-length write.
  task automatic run_transfer(input int big_kind, input bit may_abort);
    int n_raw;
    int n;
    int roll;
    int events_due;
    int span;
    roll = $urandom_range(0, 99);
    if (big_kind != 0)
      n_raw = 1;
    else if (roll < 5)
      n_raw = 0;
    else if (roll < 75)
      n_raw = $urandom_range(1, 4);
    else if (roll < 90)
      n_raw = $urandom_range(5, 8);
    else
      n_raw = $urandom_range(9, 15);
    n = (n_raw == 0) ? 1 : ((n_raw > SLOTS) ? SLOTS : n_raw);
    events_due = 0;
    for (int i = 0; i < n; i++) begin
      if (big_kind == 1) begin
        load_desc(i, 7'($urandom_range(0, 127)), 1'b1, $urandom_range(257, 511));
      end else if (big_kind == 2) begin
        ensure_bytes(i, SLOT_LEN);
        load_desc(i, 7'($urandom_range(0, 127)), 1'b0, SLOT_LEN);
      end else if (!desc_known[i] || known_len[i] > 40 || $urandom_range(0, 9) < 8) begin
        fresh_message(i);
      end
      events_due += known_len[i] + 1;
    end
    begin_transfer(4'(n_raw));
    span = events_due + $urandom_range(0, 2);
    if (may_abort && $urandom_range(0, 99) < 8)
      span = $urandom_range(0, events_due - 1);
    for (int e = 0; e < span; e++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8)
        load_byte($urandom_range(0, SLOTS - 1), $urandom_range(0, 255),
                  8'($urandom_range(0, 255)));
      else if (roll < 10)
        stray_desc();
      ctl_event($urandom_range(0, 99) < 3, 8'($urandom_range(0, 255)));
    end
  endtask

  // Short directed opening: field extremes and the named corner cases.
  task automatic directed_words();
    // Event with no transfer running.
    ctl_event(1'b0, 8'h00);
    // Write then read, joined by a repeated start.
    load_byte(0, 0, 8'hff);
    load_byte(0, 1, 8'h00);
    load_desc(0, 7'h7f, 1'b0, 2);
    load_desc(1, 7'h00, 1'b1, 1);
    begin_transfer(4'd2);
    ctl_event(1'b0, 8'h00);
    ctl_event(1'b0, 8'h00);
    ctl_event(1'b0, 8'h00);
    ctl_event(1'b0, 8'h00);
    ctl_event(1'b1, 8'hff);
    ctl_event(1'b1, 8'h00);
    // Empty message with a zero message count.
    load_desc(0, 7'h2a, 1'b0, 0);
    begin_transfer(4'd0);
    ctl_event(1'b0, 8'h5a);
    // Saturated length, then no acknowledge on the address byte.
    load_desc(0, 7'h55, 1'b1, 511);
    begin_transfer(4'd1);
    ctl_event(1'b1, 8'h00);
    // Last write byte position, and a start that aborts a running transfer.
    load_byte(7, 255, 8'ha5);
    begin_transfer(4'd1);
    begin_transfer(4'd1);
    ctl_event(1'b0, 8'h3c);
  endtask

  task automatic set_clocking(input logic [3:0] div, input logic sel);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CLK_DIV;
    cfg_wdata <= div;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_CLK_SEL;
    cfg_wdata <= {3'b000, sel};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Lets every outstanding result come back, plus the core's latency.
  task automatic wait_for_quiet();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // Watchdog: ends the run when no word moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: nothing moved for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Phases cycle the sender gaps and step the clock settings through their extremes.
  initial begin
    logic [3:0] div;
    logic       sel;
    for (int i = 0; i < SLOTS; i++) begin
      desc_known[i]     = 1'b0;
      known_len[i]      = 0;
      written_prefix[i] = 0;
    end
    for (int i = 0; i < SLOTS * SLOT_LEN; i++)
      byte_known[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 85;
        default: idle_pct = 36;
      endcase
      case (p)
        0: begin
          div = 4'h0;
          sel = 1'b1;
        end
        1: begin
          div = 4'hf;
          sel = 1'b0;
        end
        3: begin
          div = 4'hf;
          sel = 1'b1;
        end
        4: begin
          div = 4'h0;
          sel = 1'b0;
        end
        default: begin
          div = 4'($urandom_range(0, 15));
          sel = 1'($urandom_range(0, 1));
        end
      endcase
      if (p > 0)
        wait_for_quiet();
      set_clocking(div, sel);
      if (p == 0)
        directed_words();
      if (p == 1)
        run_transfer(1, 1'b0);
      if (p == 3)
        run_transfer(2, 1'b0);
      while (words_sent < WORD_TARGET * (p + 1) / PHASES)
        run_transfer(0, 1'b1);
    end
    wait_for_quiet();
    repeat (6) @(posedge clk);
    $display("Run: %0d command words over %0d clock settings, %0d results checked.",
             words_sent, PHASES, results_checked);
    $display("Transfers stopped: %0d ok, %0d on no acknowledge; %0d bytes read.",
             stops_ok, stops_nack, bytes_read);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
